/* src/mpst_pkg.sv */
// Package for the memory pattern self-test core: widths, phase codes, patterns,
// the handoff structs between the sequencer parts and the per-phase unit counts.
// No dependencies.
package mpst_pkg;

  localparam int unsigned PH_W    = 6;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned WORDS_W = 12;
  localparam int unsigned CODE_W  = 5;
  localparam int unsigned BASE_W  = 30;
  localparam int unsigned OFF_W   = 16;

  localparam logic [WORDS_W-1:0] MAX_WORDS = 12'd2048;
  localparam logic [WORDS_W-1:0] WORDS_RESET = 12'd2048;

  // Configuration register indexes
  localparam logic REG_REGION_BASE  = 1'b0;
  localparam logic REG_REGION_WORDS = 1'b1;

  // Phase codes with special meaning
  localparam logic [PH_W-1:0] PH_FIRST      = 6'd0;
  localparam logic [PH_W-1:0] PH_BYTE_SEED  = 6'd27;
  localparam logic [PH_W-1:0] PH_HALF_SEED  = 6'd29;
  localparam logic [PH_W-1:0] PH_WORD_SEED  = 6'd31;
  localparam logic [PH_W-1:0] PH_DONE       = 6'd33;
  localparam logic [PH_W-1:0] PH_IDLE       = 6'd34;

  localparam logic [CODE_W-1:0] CODE_PASS = 5'd0;

  localparam logic [31:0] PAT_ZERO     = 32'h0000_0000;
  localparam logic [31:0] PAT_ONES     = 32'hFFFF_FFFF;
  localparam logic [31:0] PAT_INC      = 32'h1234_5678;
  localparam logic [31:0] PAT_MARCH_A  = 32'h5A5A_5A5A;
  localparam logic [31:0] PAT_MARCH_B  = 32'hA5A5_A5A5;
  localparam logic [31:0] PAT_CLR_B0   = 32'hA5A5_A500;
  localparam logic [31:0] PAT_CLR_B02  = 32'hA500_A500;
  localparam logic [31:0] PAT_CLR_B012 = 32'hA500_0000;
  localparam logic [31:0] PAT_HI_HALF  = 32'hFFFF_0000;
  localparam logic [15:0] HALF_ONES    = 16'hFFFF;
  localparam logic [15:0] HALF_HI      = 16'h1234;
  localparam logic [15:0] HALF_LO      = 16'h5678;
  localparam logic [7:0]  BYTE_0       = 8'h78;
  localparam logic [7:0]  BYTE_1       = 8'h56;
  localparam logic [7:0]  BYTE_2       = 8'h34;
  localparam logic [7:0]  BYTE_3       = 8'h12;

  typedef struct packed {
    logic             valid;
    logic [PH_W-1:0]  phase;
    logic [POS_W-1:0] position;
    logic [1:0]       slot;
  } cursor_t;

  typedef struct packed {
    logic              we;
    logic [OFF_W-1:0]  word;
    logic [3:0]        be;
    logic [31:0]       data;
    logic [31:0]       exp;
    logic [31:0]       mask;
    logic [CODE_W-1:0] code;
  } access_t;

  // Number of units walked in a phase for a region of w words
  function automatic logic [POS_W-1:0] units(logic [PH_W-1:0] ph, logic [WORDS_W-1:0] w);
    logic [POS_W-1:0] n;
    case (ph)
      6'd3, 6'd28:         n = {w, 2'b00};
      6'd5, 6'd6, 6'd30:   n = {1'b0, w, 1'b0};
      6'd27, 6'd29, 6'd31: n = 14'd1;
      default:             n = {2'b00, w};
    endcase
    return n;
  endfunction

endpackage

/* src/mpst_cursor.sv */
// Cursor advance for the memory pattern self-test core: picks the next
// (phase, unit, access) to issue, skipping finished units and empty phases.
// Depends on mpst_pkg.
module mpst_cursor (
  input  logic [mpst_pkg::PH_W-1:0]    phase_i,
  input  logic [mpst_pkg::POS_W-1:0]   position_i,
  input  logic [1:0]                   slot_i,
  input  logic [mpst_pkg::WORDS_W-1:0] words_i,
  output mpst_pkg::cursor_t            cur_o
);

  logic [mpst_pkg::POS_W-1:0] unit_cnt;
  logic [mpst_pkg::POS_W:0]   pos_nx;
  logic                       in_range;
  logic                       last;
  logic [1:0]                 nslots;
  logic [mpst_pkg::PH_W-1:0]  ph_nx;
  logic [mpst_pkg::PH_W-1:0]  ph_skip;

  // First phase at or after ph_nx with at least one unit
  always_comb begin
    ph_nx = phase_i + 6'd1;
    if (words_i != '0) begin
      ph_skip = (ph_nx > mpst_pkg::PH_DONE) ? mpst_pkg::PH_DONE : ph_nx;
    end else if (ph_nx <= mpst_pkg::PH_BYTE_SEED) begin
      ph_skip = mpst_pkg::PH_BYTE_SEED;
    end else if (ph_nx <= mpst_pkg::PH_HALF_SEED) begin
      ph_skip = mpst_pkg::PH_HALF_SEED;
    end else if (ph_nx <= mpst_pkg::PH_WORD_SEED) begin
      ph_skip = mpst_pkg::PH_WORD_SEED;
    end else begin
      ph_skip = mpst_pkg::PH_DONE;
    end
  end

  always_comb begin
    unit_cnt = mpst_pkg::units(phase_i, words_i);
    pos_nx   = {1'b0, position_i} + 15'd1;
    in_range = (phase_i < mpst_pkg::PH_DONE) && (position_i < unit_cnt);
    last     = (pos_nx == {1'b0, unit_cnt});
    case (phase_i)
      6'd1, 6'd2, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd20, 6'd21, 6'd22, 6'd23: nslots = 2'd2;
      6'd5:                       nslots = 2'd3;
      6'd25:                      nslots = position_i[0] ? 2'd1 : 2'd3;
      6'd28, 6'd30, 6'd32:        nslots = last ? 2'd1 : 2'd2;
      default:                    nslots = 2'd1;
    endcase
  end

  always_comb begin
    cur_o.valid    = 1'b1;
    cur_o.phase    = phase_i;
    cur_o.position = position_i;
    cur_o.slot     = slot_i;
    if (phase_i >= mpst_pkg::PH_DONE) begin
      cur_o.valid = 1'b0;
    end else if (in_range && (slot_i < nslots)) begin
      cur_o.valid = 1'b1;
    end else if (in_range && !last) begin
      cur_o.position = pos_nx[mpst_pkg::POS_W-1:0];
      cur_o.slot     = 2'd0;
    end else begin
      cur_o.phase    = ph_skip;
      cur_o.position = '0;
      cur_o.slot     = 2'd0;
      cur_o.valid    = (ph_skip != mpst_pkg::PH_DONE);
    end
  end

endmodule

/* src/mpst_access.sv */
// Access decoder for the memory pattern self-test core: turns a cursor into one
// word access (offset, byte enables, lane data) plus the expected read lanes.
// Depends on mpst_pkg.
module mpst_access (
  input  mpst_pkg::cursor_t            cur_i,
  input  logic [mpst_pkg::WORDS_W-1:0] words_i,
  output mpst_pkg::access_t            acc_o
);

  function automatic mpst_pkg::access_t wr(logic [15:0] word, logic [3:0] be,
                                           logic [31:0] data);
    mpst_pkg::access_t a;
    a.we = 1'b1; a.word = word; a.be = be; a.data = data;
    a.exp = '0; a.mask = '0; a.code = mpst_pkg::CODE_PASS;
    return a;
  endfunction

  function automatic mpst_pkg::access_t wr_word(logic [15:0] word, logic [31:0] v);
    return wr(word, 4'hF, v);
  endfunction

  function automatic mpst_pkg::access_t wr_byte(logic [15:0] off, logic [7:0] v);
    return wr({2'b00, off[15:2]}, 4'b0001 << off[1:0], {4{v}});
  endfunction

  function automatic mpst_pkg::access_t wr_half(logic [15:0] off, logic [15:0] v);
    return wr({1'b0, off[15:1]}, off[0] ? 4'b1100 : 4'b0011, {2{v}});
  endfunction

  function automatic mpst_pkg::access_t rd(logic [15:0] word, logic [31:0] exp,
                                           logic [31:0] mask, logic [4:0] code);
    mpst_pkg::access_t a;
    a.we = 1'b0; a.word = word; a.be = 4'hF; a.data = '0;
    a.exp = exp & mask; a.mask = mask; a.code = code;
    return a;
  endfunction

  function automatic mpst_pkg::access_t rd_word(logic [15:0] word, logic [31:0] exp,
                                                logic [4:0] code);
    return rd(word, exp, mpst_pkg::PAT_ONES, code);
  endfunction

  function automatic mpst_pkg::access_t rd_byte(logic [15:0] off, logic [7:0] v,
                                                logic [4:0] code);
    return rd({2'b00, off[15:2]}, {24'd0, v} << {off[1:0], 3'b000},
              32'h0000_00FF << {off[1:0], 3'b000}, code);
  endfunction

  function automatic mpst_pkg::access_t rd_half(logic [15:0] off, logic [15:0] v,
                                                logic [4:0] code);
    return rd({1'b0, off[15:1]}, off[0] ? {v, 16'd0} : {16'd0, v},
              off[0] ? mpst_pkg::PAT_HI_HALF : {16'd0, mpst_pkg::HALF_ONES}, code);
  endfunction

  logic [13:0] p;
  logic [14:0] p1;
  logic [1:0]  s;
  logic        last;
  logic [7:0]  b4;
  logic [7:0]  b2;
  logic [31:0] q;

  always_comb begin
    p    = cur_i.position;
    p1   = {1'b0, p} + 15'd1;
    s    = cur_i.slot;
    last = (p1 == {1'b0, mpst_pkg::units(cur_i.phase, words_i)});
    b4   = {p[5:0], 2'b00};
    b2   = {p[6:0], 1'b0};
    q    = cur_i.phase[0] ? mpst_pkg::PAT_MARCH_B : mpst_pkg::PAT_MARCH_A;
    acc_o = wr_word({2'b00, p}, mpst_pkg::PAT_ZERO);
    case (cur_i.phase)
      6'd0: acc_o = wr_word({2'b00, p}, mpst_pkg::PAT_ZERO);
      6'd1: acc_o = (s == 2'd0) ? rd_word({2'b00, p}, mpst_pkg::PAT_ZERO, 5'd1)
                                : wr_word({2'b00, p}, mpst_pkg::PAT_ONES);
      6'd2: acc_o = (s == 2'd0) ? rd_word({2'b00, p}, mpst_pkg::PAT_ONES, 5'd2)
                                : wr_word({2'b00, p}, mpst_pkg::PAT_ZERO);
      6'd3: acc_o = wr_byte({2'b00, p}, p[7:0]);
      6'd4: acc_o = rd_word({2'b00, p}, {b4 + 8'd3, b4 + 8'd2, b4 + 8'd1, b4}, 5'd3);
      6'd5: begin
        case (s)
          2'd0:    acc_o = rd_byte({1'b0, p, 1'b0}, b2, 5'd4);
          2'd1:    acc_o = wr_half({2'b00, p}, {8'd0, b2});
          default: acc_o = rd_half({2'b00, p}, {8'd0, b2}, 5'd4);
        endcase
      end
      6'd6: acc_o = wr_half({2'b00, p}, {2'b00, p});
      6'd7: acc_o = rd_word({2'b00, p}, {1'b0, p, 1'b1, 1'b0, p, 1'b0}, 5'd5);
      6'd8: acc_o = wr_word({2'b00, p}, {18'd0, p});
      6'd9: acc_o = rd_word({2'b00, p}, {18'd0, p}, 5'd6);
      6'd10: acc_o = wr_word({2'b00, p}, mpst_pkg::PAT_INC);
      6'd11: acc_o = (s == 2'd0) ? rd_word({2'b00, p}, mpst_pkg::PAT_INC, 5'd7)
                                 : wr_word({2'b00, p}, mpst_pkg::PAT_MARCH_B);
      6'd12: acc_o = (s == 2'd0) ? rd_word({2'b00, p}, mpst_pkg::PAT_MARCH_B, 5'd8)
                                 : wr_byte({p, 2'b00}, 8'd0);
      6'd13: acc_o = (s == 2'd0) ? rd_word({2'b00, p}, mpst_pkg::PAT_CLR_B0, 5'd9)
                                 : wr_byte({p, 2'b10}, 8'd0);
      6'd14: acc_o = (s == 2'd0) ? rd_word({2'b00, p}, mpst_pkg::PAT_CLR_B02, 5'd10)
                                 : wr_byte({p, 2'b01}, 8'd0);
      6'd15: acc_o = (s == 2'd0) ? rd_word({2'b00, p}, mpst_pkg::PAT_CLR_B012, 5'd11)
                                 : wr_byte({p, 2'b11}, 8'd0);
      6'd16: acc_o = (s == 2'd0) ? rd_word({2'b00, p}, mpst_pkg::PAT_ZERO, 5'd12)
                                 : wr_half({1'b0, p, 1'b1}, mpst_pkg::HALF_ONES);
      6'd17: acc_o = (s == 2'd0) ? rd_word({2'b00, p}, mpst_pkg::PAT_HI_HALF, 5'd13)
                                 : wr_half({1'b0, p, 1'b0}, mpst_pkg::HALF_ONES);
      6'd18: acc_o = rd_word({2'b00, p}, mpst_pkg::PAT_ONES, 5'd14);
      6'd19: acc_o = wr_word({2'b00, p}, mpst_pkg::PAT_MARCH_A);
      6'd20, 6'd21, 6'd22, 6'd23:
        acc_o = (s == 2'd0) ? rd_word({2'b00, p}, q, 5'(cur_i.phase - 6'd5))
                            : wr_word({2'b00, p}, ~q);
      6'd24: acc_o = rd_word({2'b00, p}, mpst_pkg::PAT_MARCH_A, 5'd19);
      6'd25: begin
        if (p[0]) begin
          acc_o = wr_word({2'b00, p}, mpst_pkg::PAT_INC);
        end else if (!p[1]) begin
          case (s)
            2'd0:    acc_o = wr_byte({p, 2'b00}, mpst_pkg::BYTE_0);
            2'd1:    acc_o = wr_byte({p, 2'b01}, mpst_pkg::BYTE_1);
            default: acc_o = wr_half({1'b0, p, 1'b1}, mpst_pkg::HALF_HI);
          endcase
        end else begin
          case (s)
            2'd0:    acc_o = wr_half({1'b0, p, 1'b0}, mpst_pkg::HALF_LO);
            2'd1:    acc_o = wr_byte({p, 2'b10}, mpst_pkg::BYTE_2);
            default: acc_o = wr_byte({p, 2'b11}, mpst_pkg::BYTE_3);
          endcase
        end
      end
      6'd26: acc_o = rd_word({2'b00, p}, mpst_pkg::PAT_INC, 5'd20);
      6'd27: acc_o = wr_byte(16'd0, 8'd0);
      6'd28: acc_o = (last || s == 2'd1) ? rd_byte({8'd0, p[7:0]}, p[7:0], 5'd21)
                                         : wr_byte({8'd0, p1[7:0]}, p1[7:0]);
      6'd29: acc_o = wr_half(16'd0, 16'd0);
      6'd30: acc_o = (last || s == 2'd1) ? rd_half({2'b00, p}, {2'b00, p}, 5'd22)
                                         : wr_half({1'b0, p1}, {1'b0, p1});
      6'd31: acc_o = wr_word(16'd0, mpst_pkg::PAT_ZERO);
      6'd32: acc_o = (last || s == 2'd1) ? rd_word({2'b00, p}, {18'd0, p}, 5'd23)
                                         : wr_word({1'b0, p1}, {17'd0, p1});
      default: acc_o = wr_word({2'b00, p}, mpst_pkg::PAT_ZERO);
    endcase
  end

endmodule

/* src/memory_pattern_self_test_core.sv */
// Top level of the memory pattern self-test core: input channel, config
// registers, sequencer state and the registered result word.
// Depends on mpst_pkg, mpst_cursor and mpst_access.
//
// Usage: each input word either starts the test (kind 0) or advances it
// (kind 1), carrying the read data for the previous access when that was a
// read. Each input word yields exactly one result word: the next memory
// access (absolute word address, byte enables, lane-replicated write data) or,
// at the end, test_done with fail_code (0 pass, k = first failing check).
// The whole step is one pass of logic from the input word and sequencer state
// into the result register, so the result is registered in the cycle after its
// word is taken, and one word is taken per cycle as long as the result side keeps up.
// A result waiting in the output register while out_stall_i is high holds;
// in_stall_o rises in that case only, so a new word is taken in the same
// cycle that the waiting result leaves.
// Reset leaves the sequencer idle, region_base 0 and region_words 2048; an
// advance while idle returns an all-zero result. After the end the done
// result repeats. Write config registers only between tests.
module memory_pattern_self_test_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [29:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [31:0] read_data_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        access_valid_o,
  output logic        write_enable_o,
  output logic [29:0] word_address_o,
  output logic [3:0]  byte_enable_o,
  output logic [31:0] write_data_o,
  output logic        test_done_o,
  output logic [4:0]  fail_code_o
);

  // Config registers
  logic [mpst_pkg::BASE_W-1:0]  base_q;
  logic [mpst_pkg::WORDS_W-1:0] words_q;
  logic [mpst_pkg::WORDS_W-1:0] words_eff;

  // Sequencer state
  logic [mpst_pkg::PH_W-1:0]   phase_q, phase_d;
  logic [mpst_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [1:0]                  slot_q, slot_d;
  logic                        pend_q, pend_d;
  logic [31:0]                 exp_q, exp_d;
  logic [31:0]                 mask_q, mask_d;
  logic [mpst_pkg::CODE_W-1:0] pcode_q, pcode_d;
  logic [mpst_pkg::CODE_W-1:0] rcode_q, rcode_d;

  // Result register
  logic        out_valid_q;
  logic        acc_valid_q, acc_valid_d;
  logic        we_q, we_d;
  logic [29:0] addr_q, addr_d;
  logic [3:0]  be_q, be_d;
  logic [31:0] data_q, data_d;
  logic        done_q, done_d;
  logic [4:0]  fcode_q, fcode_d;

  logic in_take;
  logic out_take;
  logic idle_adv;
  logic mismatch;
  logic [mpst_pkg::PH_W-1:0]   ph_eff;
  logic [mpst_pkg::POS_W-1:0]  pos_eff;
  logic [1:0]                  slot_eff;
  logic [mpst_pkg::CODE_W-1:0] rcode_eff;

  mpst_pkg::cursor_t cur;
  mpst_pkg::access_t acc;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  // Clamp the region to the supported size
  assign words_eff = (words_q > mpst_pkg::MAX_WORDS) ? mpst_pkg::MAX_WORDS : words_q;

  // Check the previous read, then pick where the walk resumes
  always_comb begin
    idle_adv  = kind_i && (phase_q == mpst_pkg::PH_IDLE);
    mismatch  = kind_i && pend_q && (phase_q < mpst_pkg::PH_DONE) &&
                ((read_data_i & mask_q) != exp_q);
    ph_eff    = phase_q;
    pos_eff   = pos_q;
    slot_eff  = slot_q;
    rcode_eff = rcode_q;
    if (!kind_i) begin
      ph_eff    = mpst_pkg::PH_FIRST;
      pos_eff   = '0;
      slot_eff  = 2'd0;
      rcode_eff = mpst_pkg::CODE_PASS;
    end else if (mismatch) begin
      ph_eff    = mpst_pkg::PH_DONE;
      rcode_eff = pcode_q;
    end
  end

  mpst_cursor u_cursor (
    .phase_i    (ph_eff),
    .position_i (pos_eff),
    .slot_i     (slot_eff),
    .words_i    (words_eff),
    .cur_o      (cur)
  );

  mpst_access u_access (
    .cur_i   (cur),
    .words_i (words_eff),
    .acc_o   (acc)
  );

  // Next state and result word
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    slot_d      = slot_q;
    pend_d      = pend_q;
    exp_d       = exp_q;
    mask_d      = mask_q;
    pcode_d     = pcode_q;
    rcode_d     = rcode_q;
    acc_valid_d = 1'b0;
    we_d        = 1'b0;
    addr_d      = '0;
    be_d        = '0;
    data_d      = '0;
    done_d      = 1'b0;
    fcode_d     = mpst_pkg::CODE_PASS;
    if (!idle_adv) begin
      rcode_d = rcode_eff;
      pend_d  = 1'b0;
      if (cur.valid) begin
        phase_d     = cur.phase;
        pos_d       = cur.position;
        slot_d      = cur.slot + 2'd1;
        acc_valid_d = 1'b1;
        we_d        = acc.we;
        addr_d      = base_q + {14'd0, acc.word};
        be_d        = acc.be;
        data_d      = acc.data;
        if (!acc.we) begin
          pend_d  = 1'b1;
          exp_d   = acc.exp;
          mask_d  = acc.mask;
          pcode_d = acc.code;
        end
      end else begin
        phase_d = mpst_pkg::PH_DONE;
        done_d  = 1'b1;
        fcode_d = rcode_eff;
      end
    end
  end

  // Config and sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      words_q     <= mpst_pkg::WORDS_RESET;
      phase_q     <= mpst_pkg::PH_IDLE;
      pos_q       <= '0;
      slot_q      <= '0;
      pend_q      <= 1'b0;
      rcode_q     <= mpst_pkg::CODE_PASS;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == mpst_pkg::REG_REGION_BASE) begin
          base_q <= cfg_wdata_i;
        end else begin
          words_q <= cfg_wdata_i[mpst_pkg::WORDS_W-1:0];
        end
      end
      if (in_take) begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        slot_q      <= slot_d;
        pend_q      <= pend_d;
        rcode_q     <= rcode_d;
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: expected read lanes and the result word
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      exp_q       <= exp_d;
      mask_q      <= mask_d;
      pcode_q     <= pcode_d;
      acc_valid_q <= acc_valid_d;
      we_q        <= we_d;
      addr_q      <= addr_d;
      be_q        <= be_d;
      data_q      <= data_d;
      done_q      <= done_d;
      fcode_q     <= fcode_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign access_valid_o = acc_valid_q;
  assign write_enable_o = we_q;
  assign word_address_o = addr_q;
  assign byte_enable_o  = be_q;
  assign write_data_o   = data_q;
  assign test_done_o    = done_q;
  assign fail_code_o    = fcode_q;

endmodule

/* verif/memory_pattern_self_test_core_tb.sv */
// Self-checking testbench for memory_pattern_self_test_core: drives start and
// advance words, answers reads from a local memory image and checks every result.
// Depends on mpst_pkg and the core RTL.
module memory_pattern_self_test_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One memory operation as the sequencer sees it, before relocation
  typedef struct {
    bit        we;
    bit [31:0] word;
    bit [3:0]  be;
    bit [31:0] data;
    bit [31:0] exp;
    bit [31:0] mask;
    bit [4:0]  code;
  } mem_op_t;

  // One result word as it leaves the core
  typedef struct {
    bit        acc;
    bit        we;
    bit [29:0] addr;
    bit [3:0]  be;
    bit [31:0] data;
    bit        done;
    bit [4:0]  code;
  } access_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = mpst_pkg::REG_REGION_BASE;
  logic [29:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = 1'b0;
  logic [31:0] read_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        access_valid_o;
  logic        write_enable_o;
  logic [29:0] word_address_o;
  logic [3:0]  byte_enable_o;
  logic [31:0] write_data_o;
  logic        test_done_o;
  logic [4:0]  fail_code_o;

  localparam bit KIND_START   = 1'b0;
  localparam bit KIND_ADVANCE = 1'b1;

  memory_pattern_self_test_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sequencer state mirrored by the predictor
  bit [29:0]   cfg_base;
  bit [11:0]   cfg_words;
  bit [5:0]    seq_phase;
  int unsigned seq_pos, seq_slot;
  bit          load_pending;
  bit [31:0]   load_expect, load_mask;
  bit [4:0]    load_code, verdict;

  access_result_t expected_results[$];
  access_result_t last_result;
  bit [31:0]      mem_image [bit [29:0]];
  int             errors = 0;
  bit             quiet = 1'b0;

  function automatic mem_op_t op_store(bit [31:0] w, bit [3:0] be, bit [31:0] d);
    mem_op_t a;
    a = '{we: 1'b1, word: w, be: be, data: d, exp: 0, mask: 0, code: 0};
    return a;
  endfunction

  function automatic mem_op_t byte_store(int unsigned off, int unsigned v);
    return op_store(off >> 2, 4'b0001 << (off & 3), (v & 'hFF) * 32'h0101_0101);
  endfunction

  function automatic mem_op_t half_store(int unsigned off, int unsigned v);
    bit [15:0] h;
    h = v[15:0];
    return op_store(off >> 1, 4'b0011 << ((off & 1) * 2), {h, h});
  endfunction

  function automatic mem_op_t op_load(bit [31:0] w, bit [31:0] e, bit [31:0] m, bit [4:0] c);
    mem_op_t a;
    a = '{we: 1'b0, word: w, be: 4'hF, data: 0, exp: e & m, mask: m, code: c};
    return a;
  endfunction

  function automatic mem_op_t byte_load(int unsigned off, int unsigned v, bit [4:0] c);
    int unsigned sh;
    sh = (off & 3) * 8;
    return op_load(off >> 2, (v & 'hFF) << sh, 32'hFF << sh, c);
  endfunction

  function automatic mem_op_t half_load(int unsigned off, int unsigned v, bit [4:0] c);
    int unsigned sh;
    sh = (off & 1) * 16;
    return op_load(off >> 1, (v & 'hFFFF) << sh, 32'hFFFF << sh, c);
  endfunction

  function automatic int unsigned unit_count(int unsigned ph, int unsigned w);
    case (ph)
      3, 28:     return 4 * w;
      5, 6, 30:  return 2 * w;
      27, 29, 31: return 1;
      default:   return w;
    endcase
  endfunction

  // Access number s of unit p in phase ph; 0 once that unit has nothing left
  function automatic bit pattern_op(int unsigned ph, int unsigned p, int unsigned s,
                                    int unsigned w, output mem_op_t a);
    int unsigned b;
    bit [31:0]   q;
    bit          last;
    case (ph)
      0: if (s == 0) begin a = op_store(p, 4'hF, mpst_pkg::PAT_ZERO); return 1; end
      1: begin
        if (s == 0) begin a = op_load(p, mpst_pkg::PAT_ZERO, '1, 1); return 1; end
        if (s == 1) begin a = op_store(p, 4'hF, mpst_pkg::PAT_ONES); return 1; end
      end
      2: begin
        if (s == 0) begin a = op_load(p, mpst_pkg::PAT_ONES, '1, 2); return 1; end
        if (s == 1) begin a = op_store(p, 4'hF, mpst_pkg::PAT_ZERO); return 1; end
      end
      3: if (s == 0) begin a = byte_store(p, p); return 1; end
      4: if (s == 0) begin
        b = (4 * p) & 'hFF;
        a = op_load(p, b | ((b + 1) << 8) | ((b + 2) << 16) | ((b + 3) << 24), '1, 3);
        return 1;
      end
      5: begin
        b = (2 * p) & 'hFF;
        if (s == 0) begin a = byte_load(2 * p, b, 4); return 1; end
        if (s == 1) begin a = half_store(p, b); return 1; end
        if (s == 2) begin a = half_load(p, b, 4); return 1; end
      end
      6: if (s == 0) begin a = half_store(p, p); return 1; end
      7: if (s == 0) begin
        a = op_load(p, ((2 * p) & 'hFFFF) | (((2 * p + 1) & 'hFFFF) << 16), '1, 5);
        return 1;
      end
      8: if (s == 0) begin a = op_store(p, 4'hF, p); return 1; end
      9: if (s == 0) begin a = op_load(p, p, '1, 6); return 1; end
      10: if (s == 0) begin a = op_store(p, 4'hF, mpst_pkg::PAT_INC); return 1; end
      11: begin
        if (s == 0) begin a = op_load(p, mpst_pkg::PAT_INC, '1, 7); return 1; end
        if (s == 1) begin a = op_store(p, 4'hF, mpst_pkg::PAT_MARCH_B); return 1; end
      end
      12: begin
        if (s == 0) begin a = op_load(p, mpst_pkg::PAT_MARCH_B, '1, 8); return 1; end
        if (s == 1) begin a = byte_store(4 * p, 0); return 1; end
      end
      13: begin
        if (s == 0) begin a = op_load(p, mpst_pkg::PAT_CLR_B0, '1, 9); return 1; end
        if (s == 1) begin a = byte_store(4 * p + 2, 0); return 1; end
      end
      14: begin
        if (s == 0) begin a = op_load(p, mpst_pkg::PAT_CLR_B02, '1, 10); return 1; end
        if (s == 1) begin a = byte_store(4 * p + 1, 0); return 1; end
      end
      15: begin
        if (s == 0) begin a = op_load(p, mpst_pkg::PAT_CLR_B012, '1, 11); return 1; end
        if (s == 1) begin a = byte_store(4 * p + 3, 0); return 1; end
      end
      16: begin
        if (s == 0) begin a = op_load(p, mpst_pkg::PAT_ZERO, '1, 12); return 1; end
        if (s == 1) begin a = half_store(2 * p + 1, 'hFFFF); return 1; end
      end
      17: begin
        if (s == 0) begin a = op_load(p, mpst_pkg::PAT_HI_HALF, '1, 13); return 1; end
        if (s == 1) begin a = half_store(2 * p, 'hFFFF); return 1; end
      end
      18: if (s == 0) begin a = op_load(p, mpst_pkg::PAT_ONES, '1, 14); return 1; end
      19: if (s == 0) begin a = op_store(p, 4'hF, mpst_pkg::PAT_MARCH_A); return 1; end
      20, 21, 22, 23: begin
        q = (ph & 1) ? mpst_pkg::PAT_MARCH_B : mpst_pkg::PAT_MARCH_A;
        if (s == 0) begin a = op_load(p, q, '1, ph - 5); return 1; end
        if (s == 1) begin a = op_store(p, 4'hF, ~q); return 1; end
      end
      24: if (s == 0) begin a = op_load(p, mpst_pkg::PAT_MARCH_A, '1, 19); return 1; end
      25: begin
        if (p & 1) begin
          if (s == 0) begin a = op_store(p, 4'hF, mpst_pkg::PAT_INC); return 1; end
        end else if ((p & 3) == 0) begin
          if (s == 0) begin a = byte_store(4 * p, 'h78); return 1; end
          if (s == 1) begin a = byte_store(4 * p + 1, 'h56); return 1; end
          if (s == 2) begin a = half_store(2 * p + 1, 'h1234); return 1; end
        end else begin
          if (s == 0) begin a = half_store(2 * p, 'h5678); return 1; end
          if (s == 1) begin a = byte_store(4 * p + 2, 'h34); return 1; end
          if (s == 2) begin a = byte_store(4 * p + 3, 'h12); return 1; end
        end
      end
      26: if (s == 0) begin a = op_load(p, mpst_pkg::PAT_INC, '1, 20); return 1; end
      27: if (s == 0) begin a = byte_store(0, 0); return 1; end
      28: begin
        last = (p + 1 == 4 * w);
        if (!last && s == 0) begin a = byte_store((p + 1) & 'hFF, p + 1); return 1; end
        if (s == (last ? 0 : 1)) begin a = byte_load(p & 'hFF, p, 21); return 1; end
      end
      29: if (s == 0) begin a = half_store(0, 0); return 1; end
      30: begin
        last = (p + 1 == 2 * w);
        if (!last && s == 0) begin a = half_store(p + 1, p + 1); return 1; end
        if (s == (last ? 0 : 1)) begin a = half_load(p, p, 22); return 1; end
      end
      31: if (s == 0) begin a = op_store(0, 4'hF, mpst_pkg::PAT_ZERO); return 1; end
      32: begin
        last = (p + 1 == w);
        if (!last && s == 0) begin a = op_store(p + 1, 4'hF, p + 1); return 1; end
        if (s == (last ? 0 : 1)) begin a = op_load(p, p, '1, 23); return 1; end
      end
      default: ;
    endcase
    return 0;
  endfunction

  function automatic bit next_pattern_op(output mem_op_t a);
    int unsigned w;
    w = (cfg_words > mpst_pkg::MAX_WORDS) ? mpst_pkg::MAX_WORDS : cfg_words;
    while (seq_phase < mpst_pkg::PH_DONE) begin
      if (seq_pos >= unit_count(seq_phase, w)) begin
        seq_phase++;
        seq_pos = 0;
        seq_slot = 0;
      end else if (pattern_op(seq_phase, seq_pos, seq_slot, w, a)) begin
        seq_slot++;
        return 1;
      end else begin
        seq_pos++;
        seq_slot = 0;
      end
    end
    return 0;
  endfunction

  // Work out the result of one accepted word and advance the mirrored state
  function automatic access_result_t predict_access(bit kind, bit [31:0] rdata);
    access_result_t r;
    mem_op_t a;
    r = '{default: 0};
    if (kind == KIND_START) begin
      seq_phase = mpst_pkg::PH_FIRST;
      seq_pos = 0;
      seq_slot = 0;
      load_pending = 0;
      load_expect = 0;
      load_mask = 0;
      load_code = 0;
      verdict = mpst_pkg::CODE_PASS;
    end else begin
      if (seq_phase == mpst_pkg::PH_IDLE) return r;
      if (load_pending && seq_phase < mpst_pkg::PH_DONE &&
          ((rdata & load_mask) != load_expect)) begin
        verdict = load_code;
        seq_phase = mpst_pkg::PH_DONE;
      end
    end
    load_pending = 0;
    if (seq_phase < mpst_pkg::PH_DONE && next_pattern_op(a)) begin
      r.acc = 1;
      r.we = a.we;
      r.addr = cfg_base + a.word[29:0];
      r.be = a.be;
      r.data = a.data;
      if (!a.we) begin
        load_pending = 1;
        load_expect = a.exp;
        load_mask = a.mask;
        load_code = a.code;
      end
      return r;
    end
    seq_phase = mpst_pkg::PH_DONE;
    r.done = 1;
    r.code = verdict;
    return r;
  endfunction

  task automatic report_mismatch(string field, bit [31:0] got, bit [31:0] want);
    $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $realtime, field, got, want);
    errors++;
  endtask

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    access_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        e = expected_results.pop_front();
        if (access_valid_o !== e.acc) report_mismatch("access_valid", access_valid_o, e.acc);
        if (write_enable_o !== e.we) report_mismatch("write_enable", write_enable_o, e.we);
        if (word_address_o !== e.addr) report_mismatch("word_address", word_address_o, e.addr);
        if (byte_enable_o !== e.be) report_mismatch("byte_enable", byte_enable_o, e.be);
        if (write_data_o !== e.data) report_mismatch("write_data", write_data_o, e.data);
        if (test_done_o !== e.done) report_mismatch("test_done", test_done_o, e.done);
        if (fail_code_o !== e.code) report_mismatch("fail_code", fail_code_o, e.code);
      end
    end
  end

  // Result side: stall about a quarter of the time unless held quiet
  always @(negedge clk_i) begin
    out_stall_i <= !quiet && rst_ni && ($urandom_range(99) < 26);
  end

  // Send one word: idle first at random, hold until accepted, then predict
  task automatic send_word(bit kind, bit [31:0] rdata);
    int unsigned gap;
    if (!quiet && $urandom_range(99) < 26) begin
      gap = $urandom_range(4, 1);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i <= kind;
    read_data_i <= rdata;
    do @(posedge clk_i); while (in_stall_o);
    last_result = predict_access(kind, rdata);
    expected_results.push_back(last_result);
    if (last_result.acc && last_result.we) begin
      if (!mem_image.exists(last_result.addr)) mem_image[last_result.addr] = '0;
      for (int i = 0; i < 4; i++)
        if (last_result.be[i])
          mem_image[last_result.addr][8*i +: 8] = last_result.data[8*i +: 8];
    end
  endtask

  // Data for the next advance: the memory image for a pending read, noise otherwise
  function automatic bit [31:0] answer_word(bit corrupt);
    bit [31:0] d, flip;
    if (!load_pending) return $urandom;
    d = mem_image.exists(last_result.addr) ? mem_image[last_result.addr] : '0;
    d = (d & load_mask) | ($urandom & ~load_mask);
    if (corrupt) begin
      flip = $urandom & load_mask;
      d ^= (flip != 0) ? flip : load_mask;
    end
    return d;
  endfunction

  // Start, then advance until done (or step_limit steps), corrupting the first
  // read of check fail_check and, at random, one read in fail_odds thousand
  task automatic run_pattern_test(int unsigned fail_check, int unsigned fail_odds,
                                  int unsigned step_limit);
    bit fired;
    bit corrupt;
    int unsigned steps;
    fired = 0;
    steps = 0;
    send_word(KIND_START, $urandom);
    while (!last_result.done && (step_limit == 0 || steps < step_limit)) begin
      corrupt = load_pending && ((!fired && load_code == fail_check) ||
                                 (fail_odds != 0 && $urandom_range(999) < fail_odds));
      if (corrupt) fired = 1;
      if (fail_odds != 0 && $urandom_range(1999) == 0) send_word(KIND_START, $urandom);
      else send_word(KIND_ADVANCE, answer_word(corrupt));
      steps++;
    end
  endtask

  // Drop valid and wait for every predicted word to come back
  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_register(logic index, bit [29:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == mpst_pkg::REG_REGION_BASE) cfg_base = value;
    else cfg_words = value[11:0];
  endtask

  task automatic test_idle_advance;
    // advances before any start return an all-zero word
    repeat (3) send_word(KIND_ADVANCE, $urandom);
    send_word(KIND_ADVANCE, 32'hFFFF_FFFF);
    send_word(KIND_ADVANCE, 32'h0000_0000);
    drain();
  endtask

  task automatic test_clean_pass;
    // no idling here; the region wraps the top of the address space
    quiet = 1'b1;
    write_register(mpst_pkg::REG_REGION_BASE, 30'h3FFF_FFFC);
    write_register(mpst_pkg::REG_REGION_WORDS, 30'd8);
    run_pattern_test(0, 0, 0);
    repeat (2) send_word(KIND_ADVANCE, $urandom);
    drain();
    quiet = 1'b0;
  endtask

  task automatic test_each_check_fails;
    write_register(mpst_pkg::REG_REGION_WORDS, 30'd1);
    for (int unsigned k = 1; k <= 23; k++) begin
      write_register(mpst_pkg::REG_REGION_BASE, 30'($urandom));
      run_pattern_test(k, 0, 0);
      send_word(KIND_ADVANCE, $urandom);
      drain();
    end
  endtask

  task automatic test_restart_large;
    // largest region, top base; restart mid-test twice, then an oversized region
    write_register(mpst_pkg::REG_REGION_BASE, 30'h3FFF_FFFF);
    write_register(mpst_pkg::REG_REGION_WORDS, 30'd2048);
    run_pattern_test(0, 0, 80);
    run_pattern_test(0, 0, 40);
    drain();
    write_register(mpst_pkg::REG_REGION_BASE, 30'd0);
    write_register(mpst_pkg::REG_REGION_WORDS, 30'd4095);
    run_pattern_test(0, 0, 30);
    drain();
  endtask

  task automatic test_random_runs;
    for (int r = 0; r < 2; r++) begin
      write_register(mpst_pkg::REG_REGION_BASE, 30'($urandom));
      write_register(mpst_pkg::REG_REGION_WORDS, 30'($urandom_range(2, 1)));
      run_pattern_test(0, 1, 0);
      send_word(KIND_ADVANCE, $urandom);
      drain();
    end
  endtask

  initial begin
    cfg_base = '0;
    cfg_words = mpst_pkg::WORDS_RESET;
    seq_phase = mpst_pkg::PH_IDLE;
    seq_pos = 0;
    seq_slot = 0;
    load_pending = 0;
    load_expect = 0;
    load_mask = 0;
    load_code = 0;
    verdict = mpst_pkg::CODE_PASS;
    last_result = '{default: 0};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_advance();
    test_clean_pass();
    test_each_check_fails();
    test_restart_large();
    test_random_runs();

    if (errors == 0) $display("memory_pattern_self_test_core_tb passed");
    else $display("memory_pattern_self_test_core_tb failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("memory_pattern_self_test_core_tb failed");
    $finish;
  end

endmodule
